[rtl/tpq_pkg.sv]
// Shared constants, codes and controller/datapath types for the two-priority
// transmit packet queue. No dependencies.
`default_nettype none
package tpq_pkg;

  localparam int HI_DEPTH  = 4;
  localparam int NM_DEPTH  = 8;
  localparam int ITEM_MAX  = 64;

  localparam int HI_SLOT_W = $clog2(HI_DEPTH);
  localparam int NM_SLOT_W = $clog2(NM_DEPTH);
  localparam int IDX_W     = $clog2(ITEM_MAX);
  localparam int LEN_W     = $clog2(ITEM_MAX + 2);
  localparam int HI_FILL_W = $clog2(HI_DEPTH + 1);
  localparam int NM_FILL_W = $clog2(NM_DEPTH + 1);
  localparam int HI_ADDR_W = HI_SLOT_W + IDX_W;
  localparam int NM_ADDR_W = NM_SLOT_W + IDX_W;

  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [15:0] GUARD_RST   = 16'd20;
  localparam logic [7:0]  ACK_RST     = 8'd0;

  // input modes
  localparam logic [2:0] MODE_BYTE     = 3'd0;
  localparam logic [2:0] MODE_TICK     = 3'd1;
  localparam logic [2:0] MODE_DONE     = 3'd2;
  localparam logic [2:0] MODE_DISPATCH = 3'd3;
  localparam logic [2:0] MODE_CONN_RST = 3'd4;

  // result status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_FULL      = 4'd1;
  localparam logic [3:0] ST_BADLEN    = 4'd2;
  localparam logic [3:0] ST_STALE     = 4'd3;
  localparam logic [3:0] ST_TIMEOUT   = 4'd4;
  localparam logic [3:0] ST_IDLE      = 4'd5;
  localparam logic [3:0] ST_LINK_BUSY = 4'd6;
  localparam logic [3:0] ST_LINK_FAIL = 4'd7;
  localparam logic [3:0] ST_STAGED    = 4'd8;
  localparam logic [3:0] ST_RESET     = 4'd9;

  localparam logic [1:0] LINK_OK   = 2'd0;
  localparam logic [1:0] LINK_BUSY = 2'd1;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_GUARD   = 2'd1;
  localparam logic [1:0] CFG_ACK     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_SEND_RD,
    S_SEND_LD,
    S_SEND_OUT,
    S_OUT
  } tpq_state_t;

  typedef struct packed {
    logic accept;
    logic copy_step;
    logic send_load;
    logic send_adv;
  } tpq_cmd_t;

  typedef struct packed {
    logic need_copy;
    logic need_send;
    logic copy_done;
    logic send_last;
  } tpq_stat_t;

endpackage
`default_nettype wire

[rtl/tpq_in_if.sv]
// Input channel: valid/ready handshake with one queue command transaction.
// Depends on nothing.
`default_nettype none
interface tpq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] in_byte;
  logic       in_last;
  logic       done_queue;
  logic [2:0] done_slot;
  logic       device_configured;
  logic [1:0] link_result;

  modport source (output valid, mode, in_byte, in_last, done_queue, done_slot,
                  device_configured, link_result, input ready);
  modport sink (input valid, mode, in_byte, in_last, done_queue, done_slot,
                device_configured, link_result, output ready);
endinterface
`default_nettype wire

[rtl/tpq_out_if.sv]
// Result channel: valid/ready handshake with one status or packet byte.
// Depends on nothing.
`default_nettype none
interface tpq_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  status;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_queue;
  logic [2:0]  out_slot;
  logic        busy_res;
  logic [2:0]  high_count;
  logic [3:0]  normal_count;
  logic [31:0] fail_count;
  logic [31:0] drop_count;

  modport source (output valid, kind, status, out_byte, out_last, out_queue, out_slot,
                  busy_res, high_count, normal_count, fail_count, drop_count,
                  input ready);
  modport sink (input valid, kind, status, out_byte, out_last, out_queue, out_slot,
                busy_res, high_count, normal_count, fail_count, drop_count,
                output ready);
endinterface
`default_nettype wire

[rtl/tpq_cfg_if.sv]
// Configuration write channel: valid/ready, register index and data.
// Depends on nothing.
`default_nettype none
interface tpq_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/tpq_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/tpq_ctrl.sv]
// Sequencer for the packet queue: item acceptance, commit copy, byte streaming
// and result hand-off. Depends on tpq_pkg.
`default_nettype none
module tpq_ctrl
  import tpq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire tpq_stat_t stat,
  output tpq_cmd_t       cmd
);
  tpq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.need_copy) begin
            state_nxt = S_COPY;
          end else if (stat.need_send) begin
            state_nxt = S_SEND_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_done) begin
          state_nxt = S_OUT;
        end
      end
      // wait for the registered store read
      S_SEND_RD: begin
        state_nxt = S_SEND_LD;
      end
      S_SEND_LD: begin
        cmd.send_load = 1'b1;
        state_nxt     = S_SEND_OUT;
      end
      S_SEND_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.send_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.send_adv = 1'b1;
            state_nxt    = S_SEND_RD;
          end
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

[rtl/tpq_dp.sv]
// Datapath for the packet queue: staging, both packet stores, queue pointers,
// timers, counters and the result register. Depends on tpq_pkg and tpq_ram.
`default_nettype none
module tpq_dp
  import tpq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire tpq_cmd_t    cmd,
  output tpq_stat_t        stat,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [2:0]  mode,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  input  wire logic        done_queue,
  input  wire logic [2:0]  done_slot,
  input  wire logic        device_configured,
  input  wire logic [1:0]  link_result,
  output logic             kind,
  output logic [3:0]       status,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_queue,
  output logic [2:0]       out_slot,
  output logic             busy_res,
  output logic [2:0]       high_count,
  output logic [3:0]       normal_count,
  output logic [31:0]      fail_count,
  output logic [31:0]      drop_count
);
  localparam int HI_SUM_W = HI_FILL_W + 1;
  localparam int NM_SUM_W = NM_FILL_W + 1;

  // configuration
  logic [15:0] timeout_r, guard_r;
  logic [7:0]  ack_r;

  // control state
  logic [LEN_W-1:0]     stg_len_r, stg_len_nxt;
  logic [7:0]           byte2_r, byte2_nxt;
  logic [HI_SLOT_W-1:0] hi_head_r, hi_head_nxt;
  logic [HI_FILL_W-1:0] hi_fill_r, hi_fill_nxt;
  logic [NM_SLOT_W-1:0] nm_head_r, nm_head_nxt;
  logic [NM_FILL_W-1:0] nm_fill_r, nm_fill_nxt;
  logic                 in_flight_r, in_flight_nxt;
  logic                 active_high_r, active_high_nxt;
  logic [31:0]          now_r, now_nxt;
  logic [31:0]          start_r, start_nxt;
  logic [31:0]          guard_until_r, guard_until_nxt;
  logic [31:0]          fail_r, fail_nxt;
  logic [31:0]          dropped_r, dropped_nxt;

  logic [LEN_W-1:0] hi_len_r [HI_DEPTH];
  logic [LEN_W-1:0] nm_len_r [NM_DEPTH];

  // commit copy and send sequencing
  logic [LEN_W-1:0]     copy_cnt_r, copy_len_r;
  logic                 copy_high_r;
  logic [HI_SLOT_W-1:0] copy_tail_hi_r;
  logic [NM_SLOT_W-1:0] copy_tail_nm_r;
  logic [IDX_W-1:0]     send_idx_r;
  logic [LEN_W-1:0]     send_len_r;
  logic                 send_high_r;
  logic [2:0]           send_slot_r;

  // result register
  logic       o_kind_r, o_last_r, o_queue_r;
  logic [3:0] o_status_r;
  logic [7:0] o_byte_r;
  logic [2:0] o_slot_r;

  // item decode
  logic [LEN_W-1:0]     stg_len_inc;
  logic [7:0]           b2;
  logic                 to_high;
  logic [HI_SUM_W-1:0]  hi_sum;
  logic [NM_SUM_W-1:0]  nm_sum;
  logic [HI_SLOT_W-1:0] hi_tail, hi_head_inc;
  logic [NM_SLOT_W-1:0] nm_tail, nm_head_inc;
  logic [31:0]          elapsed, gdiff;
  logic [LEN_W-1:0]     sel_len, sel_len_cl;
  logic                 sel_high;
  logic [2:0]           sel_slot;
  logic                 match;
  logic [3:0]           st_code;
  logic                 need_copy, need_send;

  // RAM ports
  logic                 stg_we;
  logic [7:0]           stg_rdata;
  logic                 hi_we, nm_we;
  logic [HI_ADDR_W-1:0] hi_waddr, hi_raddr;
  logic [NM_ADDR_W-1:0] nm_waddr, nm_raddr;
  logic [IDX_W-1:0]     copy_idx;
  logic [7:0]           hi_rdata, nm_rdata;
  logic                 copy_done;

  assign stg_len_inc = (stg_len_r <= LEN_W'(ITEM_MAX)) ? stg_len_r + LEN_W'(1) : stg_len_r;
  assign b2          = (stg_len_r == LEN_W'(2)) ? in_byte : byte2_r;
  assign to_high     = (stg_len_inc >= LEN_W'(3)) && (b2 == ack_r);

  assign hi_sum  = HI_SUM_W'(hi_head_r) + HI_SUM_W'(hi_fill_r);
  assign nm_sum  = NM_SUM_W'(nm_head_r) + NM_SUM_W'(nm_fill_r);
  assign hi_tail = (hi_sum >= HI_SUM_W'(HI_DEPTH)) ? HI_SLOT_W'(hi_sum - HI_SUM_W'(HI_DEPTH))
                                                   : HI_SLOT_W'(hi_sum);
  assign nm_tail = (nm_sum >= NM_SUM_W'(NM_DEPTH)) ? NM_SLOT_W'(nm_sum - NM_SUM_W'(NM_DEPTH))
                                                   : NM_SLOT_W'(nm_sum);
  assign hi_head_inc = (hi_head_r == HI_SLOT_W'(HI_DEPTH - 1)) ? '0
                                                               : hi_head_r + HI_SLOT_W'(1);
  assign nm_head_inc = (nm_head_r == NM_SLOT_W'(NM_DEPTH - 1)) ? '0
                                                               : nm_head_r + NM_SLOT_W'(1);

  assign elapsed = now_r - start_r;
  assign gdiff   = now_r - guard_until_r;

  assign sel_high   = (hi_fill_r != '0);
  assign sel_len    = sel_high ? hi_len_r[hi_head_r] : nm_len_r[nm_head_r];
  assign sel_slot   = sel_high ? 3'(hi_head_r) : 3'(nm_head_r);
  assign sel_len_cl = (sel_len > LEN_W'(ITEM_MAX)) ? LEN_W'(ITEM_MAX) :
                      (sel_len == '0) ? LEN_W'(1) : sel_len;

  always_comb begin
    match = 1'b0;
    if (in_flight_r) begin
      if (active_high_r) begin
        match = done_queue && (hi_fill_r != '0) && (done_slot == 3'(hi_head_r));
      end else begin
        match = !done_queue && (nm_fill_r != '0) && (done_slot == 3'(nm_head_r));
      end
    end
  end

  always_comb begin
    stg_len_nxt     = stg_len_r;
    byte2_nxt       = byte2_r;
    hi_head_nxt     = hi_head_r;
    hi_fill_nxt     = hi_fill_r;
    nm_head_nxt     = nm_head_r;
    nm_fill_nxt     = nm_fill_r;
    in_flight_nxt   = in_flight_r;
    active_high_nxt = active_high_r;
    now_nxt         = now_r;
    start_nxt       = start_r;
    guard_until_nxt = guard_until_r;
    fail_nxt        = fail_r;
    dropped_nxt     = dropped_r;
    st_code         = ST_IDLE;
    need_copy       = 1'b0;
    need_send       = 1'b0;
    case (mode)
      MODE_BYTE: begin
        stg_len_nxt = stg_len_inc;
        byte2_nxt   = b2;
        if (!in_last) begin
          st_code = ST_STAGED;
        end else begin
          stg_len_nxt = '0;
          st_code     = ST_OK;
          if (stg_len_inc > LEN_W'(ITEM_MAX)) begin
            fail_nxt = fail_r + 32'd1;
            st_code  = ST_BADLEN;
          end else if (to_high) begin
            if (hi_fill_r >= HI_FILL_W'(HI_DEPTH)) begin
              fail_nxt = fail_r + 32'd1;
              st_code  = ST_FULL;
            end else begin
              need_copy = 1'b1;
            end
          end else begin
            if (nm_fill_r >= NM_FILL_W'(NM_DEPTH)) begin
              fail_nxt = fail_r + 32'd1;
              st_code  = ST_FULL;
            end else begin
              need_copy = 1'b1;
            end
          end
        end
      end
      MODE_TICK: begin
        now_nxt = now_r + 32'd1;
        st_code = ST_OK;
      end
      MODE_DONE: begin
        if (!match) begin
          st_code = ST_STALE;
        end else begin
          st_code = ST_OK;
          if (active_high_r) begin
            hi_head_nxt = hi_head_inc;
            hi_fill_nxt = hi_fill_r - HI_FILL_W'(1);
          end else begin
            nm_head_nxt = nm_head_inc;
            nm_fill_nxt = nm_fill_r - NM_FILL_W'(1);
          end
          in_flight_nxt   = 1'b0;
          active_high_nxt = 1'b0;
          start_nxt       = '0;
        end
      end
      MODE_DISPATCH: begin
        if (in_flight_r) begin
          if (elapsed < {16'd0, timeout_r}) begin
            st_code = ST_IDLE;
          end else begin
            // drop the active head and start the guard
            if (active_high_r) begin
              if (hi_fill_r != '0) begin
                hi_head_nxt = hi_head_inc;
                hi_fill_nxt = hi_fill_r - HI_FILL_W'(1);
              end
            end else if (nm_fill_r != '0) begin
              nm_head_nxt = nm_head_inc;
              nm_fill_nxt = nm_fill_r - NM_FILL_W'(1);
            end
            in_flight_nxt   = 1'b0;
            active_high_nxt = 1'b0;
            start_nxt       = '0;
            guard_until_nxt = now_r + {16'd0, guard_r};
            dropped_nxt     = dropped_r + 32'd1;
            st_code         = ST_TIMEOUT;
          end
        end else if (!device_configured || gdiff[31] ||
                     (hi_fill_r == '0 && nm_fill_r == '0)) begin
          st_code = ST_IDLE;
        end else if (link_result == LINK_BUSY) begin
          st_code = ST_LINK_BUSY;
        end else if (link_result != LINK_OK) begin
          fail_nxt = fail_r + 32'd1;
          st_code  = ST_LINK_FAIL;
        end else begin
          need_send       = 1'b1;
          st_code         = ST_OK;
          in_flight_nxt   = 1'b1;
          active_high_nxt = sel_high;
          start_nxt       = now_r;
        end
      end
      MODE_CONN_RST: begin
        dropped_nxt     = dropped_r + 32'(hi_fill_r) + 32'(nm_fill_r);
        hi_head_nxt     = '0;
        hi_fill_nxt     = '0;
        nm_head_nxt     = '0;
        nm_fill_nxt     = '0;
        in_flight_nxt   = 1'b0;
        active_high_nxt = 1'b0;
        start_nxt       = '0;
        guard_until_nxt = now_r + {16'd0, guard_r};
        st_code         = ST_RESET;
      end
      default: begin
        st_code = ST_IDLE;
      end
    endcase
  end

  assign copy_done = (copy_cnt_r == copy_len_r);
  assign copy_idx  = IDX_W'(copy_cnt_r - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RST;
      guard_r       <= GUARD_RST;
      ack_r         <= ACK_RST;
      stg_len_r     <= '0;
      hi_head_r     <= '0;
      hi_fill_r     <= '0;
      nm_head_r     <= '0;
      nm_fill_r     <= '0;
      in_flight_r   <= 1'b0;
      active_high_r <= 1'b0;
      now_r         <= '0;
      start_r       <= '0;
      guard_until_r <= '0;
      fail_r        <= '0;
      dropped_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_data;
          CFG_GUARD:   guard_r   <= cfg_data;
          CFG_ACK:     ack_r     <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        stg_len_r     <= stg_len_nxt;
        hi_head_r     <= hi_head_nxt;
        hi_fill_r     <= hi_fill_nxt;
        nm_head_r     <= nm_head_nxt;
        nm_fill_r     <= nm_fill_nxt;
        in_flight_r   <= in_flight_nxt;
        active_high_r <= active_high_nxt;
        now_r         <= now_nxt;
        start_r       <= start_nxt;
        guard_until_r <= guard_until_nxt;
        fail_r        <= fail_nxt;
        dropped_r     <= dropped_nxt;
      end else if (cmd.copy_step && copy_done) begin
        // commit the copied packet at the tail
        if (copy_high_r) begin
          hi_fill_r <= hi_fill_r + HI_FILL_W'(1);
        end else begin
          nm_fill_r <= nm_fill_r + NM_FILL_W'(1);
        end
      end
    end
  end

  // payload and sequencing registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte2_r <= byte2_nxt;
      if (need_copy) begin
        copy_cnt_r     <= '0;
        copy_len_r     <= stg_len_inc;
        copy_high_r    <= to_high;
        copy_tail_hi_r <= hi_tail;
        copy_tail_nm_r <= nm_tail;
      end else if (need_send) begin
        send_idx_r  <= '0;
        send_len_r  <= sel_len_cl;
        send_high_r <= sel_high;
        send_slot_r <= sel_slot;
      end else begin
        o_kind_r   <= 1'b0;
        o_status_r <= st_code;
        o_byte_r   <= '0;
        o_last_r   <= 1'b0;
        o_queue_r  <= 1'b0;
        o_slot_r   <= '0;
      end
    end
    if (cmd.copy_step) begin
      if (copy_done) begin
        if (copy_high_r) begin
          hi_len_r[copy_tail_hi_r] <= copy_len_r;
        end else begin
          nm_len_r[copy_tail_nm_r] <= copy_len_r;
        end
        o_kind_r   <= 1'b0;
        o_status_r <= ST_OK;
        o_byte_r   <= '0;
        o_last_r   <= 1'b0;
        o_queue_r  <= 1'b0;
        o_slot_r   <= '0;
      end else begin
        copy_cnt_r <= copy_cnt_r + LEN_W'(1);
      end
    end
    if (cmd.send_load) begin
      o_kind_r   <= 1'b1;
      o_status_r <= ST_OK;
      o_byte_r   <= send_high_r ? hi_rdata : nm_rdata;
      o_last_r   <= (LEN_W'(send_idx_r) + LEN_W'(1) == send_len_r);
      o_queue_r  <= send_high_r;
      o_slot_r   <= send_slot_r;
    end
    if (cmd.send_adv) begin
      send_idx_r <= send_idx_r + IDX_W'(1);
    end
  end

  assign stg_we = cmd.accept && (mode == MODE_BYTE) && (stg_len_r < LEN_W'(ITEM_MAX));

  tpq_ram #(.WIDTH(8), .DEPTH(ITEM_MAX)) u_stg_ram (
    .clk   (clk),
    .we    (stg_we),
    .waddr (IDX_W'(stg_len_r)),
    .wdata (in_byte),
    .raddr (IDX_W'(copy_cnt_r)),
    .rdata (stg_rdata)
  );

  // the store write takes the staging read data in the following cycle
  assign hi_we    = cmd.copy_step && copy_high_r && (copy_cnt_r != '0);
  assign nm_we    = cmd.copy_step && !copy_high_r && (copy_cnt_r != '0);
  assign hi_waddr = {copy_tail_hi_r, copy_idx};
  assign nm_waddr = {copy_tail_nm_r, copy_idx};
  assign hi_raddr = {send_slot_r[HI_SLOT_W-1:0], send_idx_r};
  assign nm_raddr = {send_slot_r[NM_SLOT_W-1:0], send_idx_r};

  tpq_ram #(.WIDTH(8), .DEPTH(HI_DEPTH * ITEM_MAX)) u_hi_ram (
    .clk   (clk),
    .we    (hi_we),
    .waddr (hi_waddr),
    .wdata (stg_rdata),
    .raddr (hi_raddr),
    .rdata (hi_rdata)
  );

  tpq_ram #(.WIDTH(8), .DEPTH(NM_DEPTH * ITEM_MAX)) u_nm_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (stg_rdata),
    .raddr (nm_raddr),
    .rdata (nm_rdata)
  );

  assign stat.need_copy = need_copy;
  assign stat.need_send = need_send;
  assign stat.copy_done = copy_done;
  assign stat.send_last = o_last_r;

  assign kind         = o_kind_r;
  assign status       = o_status_r;
  assign out_byte     = o_byte_r;
  assign out_last     = o_last_r;
  assign out_queue    = o_queue_r;
  assign out_slot     = o_slot_r;
  assign busy_res     = in_flight_r;
  assign high_count   = 3'(hi_fill_r);
  assign normal_count = 4'(nm_fill_r);
  assign fail_count   = fail_r;
  assign drop_count   = dropped_r;
endmodule
`default_nettype wire

[rtl/two_priority_tx_packet_queue_unit.sv]
// Two-priority transmit packet queue. A status that needs no commit copy is offered in the
// cycle after its item is accepted. A committed packet is copied from staging into its
// store before its status. A dispatch streams its packet one byte at a time (store
// read, result load, hand-off), the read step set by the registered packet store read.
// Synchronous reset flushes both queues and clears counters; stores need no clearing.
`default_nettype none
module two_priority_tx_packet_queue_unit
  import tpq_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  tpq_in_if.sink   in_ch,
  tpq_out_if.source out_ch,
  tpq_cfg_if.sink  cfg_ch
);
  tpq_cmd_t  cmd;
  tpq_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  tpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .mode              (in_ch.mode),
    .in_byte           (in_ch.in_byte),
    .in_last           (in_ch.in_last),
    .done_queue        (in_ch.done_queue),
    .done_slot         (in_ch.done_slot),
    .device_configured (in_ch.device_configured),
    .link_result       (in_ch.link_result),
    .kind              (out_ch.kind),
    .status            (out_ch.status),
    .out_byte          (out_ch.out_byte),
    .out_last          (out_ch.out_last),
    .out_queue         (out_ch.out_queue),
    .out_slot          (out_ch.out_slot),
    .busy_res          (out_ch.busy_res),
    .high_count        (out_ch.high_count),
    .normal_count      (out_ch.normal_count),
    .fail_count        (out_ch.fail_count),
    .drop_count        (out_ch.drop_count)
  );

  // never take a new item while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while result pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.high_count <= 3'(HI_DEPTH) && out_ch.normal_count <= 4'(NM_DEPTH))
    else $error("queue fill beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.busy_res) |-> $past(in_ch.valid && in_ch.ready &&
                                     in_ch.mode == MODE_DISPATCH))
    else $error("transfer started without a dispatch");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind |-> out_ch.busy_res)
    else $error("packet byte sent with nothing in flight");
endmodule
`default_nettype wire

[tb/tb_two_priority_tx_packet_queue_unit.sv]
// Testbench for the two-priority transmit packet queue: drives command transactions,
// predicts every status and packet byte result and compares them field by field.
// Depends on tpq_pkg, the three channel interfaces and the queue unit.
`timescale 1ns / 1ps
module tb_two_priority_tx_packet_queue_unit
  import tpq_pkg::*;
();

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] in_byte;
    logic       in_last;
    logic       done_queue;
    logic [2:0] done_slot;
    logic       device_configured;
    logic [1:0] link_result;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  status;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        out_queue;
    logic [2:0]  out_slot;
    logic        busy_res;
    logic [2:0]  high_count;
    logic [3:0]  normal_count;
    logic [31:0] fail_count;
    logic [31:0] drop_count;
  } res_t;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  tpq_in_if  in_ch ();
  tpq_out_if out_ch ();
  tpq_cfg_if cfg_ch ();

  two_priority_tx_packet_queue_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // queue model state
  logic [15:0] timeout_ms, guard_ms;
  logic [7:0]  ack_id;
  logic [7:0]  hi_data [HI_DEPTH][ITEM_MAX];
  logic [7:0]  nm_data [NM_DEPTH][ITEM_MAX];
  int unsigned hi_len [HI_DEPTH];
  int unsigned nm_len [NM_DEPTH];
  logic [7:0]  stage [ITEM_MAX];
  int unsigned stage_len;
  int unsigned hi_head, hi_fill, nm_head, nm_fill;
  bit          in_flight, active_high;
  logic [31:0] now_ms, start_ms, guard_until, fail_total, dropped_total;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   errors = 0;
  bit   no_idle = 1'b0;
  int   quiet_cycles = 0;

  task automatic report(input string what, input res_t got, input res_t want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  function automatic void push_result(input bit kind, input logic [3:0] st,
                                      input logic [7:0] b, input bit last,
                                      input bit q, input logic [2:0] slot);
    res_t r;
    r.kind = kind; r.status = st; r.out_byte = b; r.out_last = last;
    r.out_queue = q; r.out_slot = slot; r.busy_res = in_flight;
    r.high_count = hi_fill[2:0]; r.normal_count = nm_fill[3:0];
    r.fail_count = fail_total; r.drop_count = dropped_total;
    expected_results.push_back(r);
  endfunction

  function automatic void pop_active_slot();
    if (active_high) begin
      if (hi_fill != 0) begin hi_head = (hi_head + 1) % HI_DEPTH; hi_fill--; end
    end else if (nm_fill != 0) begin
      nm_head = (nm_head + 1) % NM_DEPTH; nm_fill--;
    end
  endfunction

  function automatic logic [3:0] commit_packet();
    int unsigned len, tail;
    bit hi;
    len = stage_len;
    hi = len >= 3 && stage[2] == ack_id;
    stage_len = 0;
    if (len == 0 || len > ITEM_MAX) begin fail_total++; return ST_BADLEN; end
    if (hi) begin
      if (hi_fill >= HI_DEPTH) begin fail_total++; return ST_FULL; end
      tail = (hi_head + hi_fill) % HI_DEPTH;
      for (int i = 0; i < len; i++) hi_data[tail][i] = stage[i];
      hi_len[tail] = len; hi_fill++;
    end else begin
      if (nm_fill >= NM_DEPTH) begin fail_total++; return ST_FULL; end
      tail = (nm_head + nm_fill) % NM_DEPTH;
      for (int i = 0; i < len; i++) nm_data[tail][i] = stage[i];
      nm_len[tail] = len; nm_fill++;
    end
    return ST_OK;
  endfunction

  function automatic void predict_queue_step(input cmd_t c);
    logic [31:0] diff;
    bit hi, hit;
    int unsigned slot, len;
    case (c.mode)
      MODE_BYTE: begin
        if (stage_len < ITEM_MAX) stage[stage_len] = c.in_byte;
        if (stage_len <= ITEM_MAX) stage_len++;
        if (!c.in_last) push_result(0, ST_STAGED, 0, 0, 0, 0);
        else push_result(0, commit_packet(), 0, 0, 0, 0);
      end
      MODE_TICK: begin
        now_ms++;
        push_result(0, ST_OK, 0, 0, 0, 0);
      end
      MODE_DONE: begin
        hit = 0;
        if (in_flight) begin
          if (active_high) hit = c.done_queue && hi_fill != 0 && c.done_slot == hi_head;
          else hit = !c.done_queue && nm_fill != 0 && c.done_slot == nm_head;
        end
        if (!hit) push_result(0, ST_STALE, 0, 0, 0, 0);
        else begin
          pop_active_slot();
          in_flight = 0; active_high = 0; start_ms = 0;
          push_result(0, ST_OK, 0, 0, 0, 0);
        end
      end
      MODE_DISPATCH: begin
        diff = now_ms - guard_until;
        if (in_flight) begin
          if (now_ms - start_ms < {16'd0, timeout_ms}) push_result(0, ST_IDLE, 0, 0, 0, 0);
          else begin
            pop_active_slot();
            in_flight = 0; active_high = 0; start_ms = 0;
            guard_until = now_ms + guard_ms;
            dropped_total++;
            push_result(0, ST_TIMEOUT, 0, 0, 0, 0);
          end
        end else if (!c.device_configured || diff[31] || (hi_fill == 0 && nm_fill == 0))
          push_result(0, ST_IDLE, 0, 0, 0, 0);
        else if (c.link_result == LINK_BUSY) push_result(0, ST_LINK_BUSY, 0, 0, 0, 0);
        else if (c.link_result != LINK_OK) begin
          fail_total++;
          push_result(0, ST_LINK_FAIL, 0, 0, 0, 0);
        end else begin
          hi = hi_fill != 0;
          slot = hi ? hi_head : nm_head;
          len = hi ? hi_len[slot] : nm_len[slot];
          in_flight = 1; active_high = hi; start_ms = now_ms;
          for (int i = 0; i < len; i++)
            push_result(1, ST_OK, hi ? hi_data[slot][i] : nm_data[slot][i],
                        i + 1 == len, hi, slot[2:0]);
        end
      end
      MODE_CONN_RST: begin
        dropped_total += hi_fill + nm_fill;
        hi_head = 0; hi_fill = 0; nm_head = 0; nm_fill = 0;
        in_flight = 0; active_high = 0; start_ms = 0;
        guard_until = now_ms + guard_ms;
        push_result(0, ST_RESET, 0, 0, 0, 0);
      end
      default: push_result(0, ST_IDLE, 0, 0, 0, 0);
    endcase
  endfunction

  function automatic cmd_t mk(input logic [2:0] m, input logic [7:0] b = 0,
                              input bit last = 0, input bit dq = 0,
                              input logic [2:0] ds = 0, input bit conf = 1,
                              input logic [1:0] link = LINK_OK);
    cmd_t c;
    c.mode = m; c.in_byte = b; c.in_last = last; c.done_queue = dq;
    c.done_slot = ds; c.device_configured = conf; c.link_result = link;
    return c;
  endfunction

  // pick the completion queue at random
  function automatic bit active_high_guess();
    return 1'($urandom_range(0, 1));
  endfunction

  // queue a packet; third byte optionally forced to the ack id
  task automatic add_packet(input int len, input bit urgent);
    for (int i = 0; i < len; i++)
      pending_cmds.push_back(mk(MODE_BYTE,
                                (i == 2 && urgent) ? ack_id : 8'($urandom_range(0, 255)),
                                i == len - 1));
  endtask

  task automatic add_ticks(input int n);
    repeat (n) pending_cmds.push_back(mk(MODE_TICK));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_cmds.size() != 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        predict_queue_step(c);
        in_ch.valid <= 1'b1;
        {in_ch.mode, in_ch.in_byte, in_ch.in_last, in_ch.done_queue, in_ch.done_slot,
         in_ch.device_configured, in_ch.link_result} <= c;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        res_t got, want;
        got = {out_ch.kind, out_ch.status, out_ch.out_byte, out_ch.out_last,
               out_ch.out_queue, out_ch.out_slot, out_ch.busy_res, out_ch.high_count,
               out_ch.normal_count, out_ch.fail_count, out_ch.drop_count};
        if (expected_results.size() == 0) report("unexpected result", got, got);
        else begin
          want = expected_results.pop_front();
          if (got.kind != want.kind) report("kind", got, want);
          if (got.status != want.status) report("status", got, want);
          if (got.out_byte != want.out_byte) report("out_byte", got, want);
          if (got.out_last != want.out_last) report("out_last", got, want);
          if (got.out_queue != want.out_queue) report("out_queue", got, want);
          if (got.out_slot != want.out_slot) report("out_slot", got, want);
          if (got.busy_res != want.busy_res) report("busy_res", got, want);
          if (got.high_count != want.high_count) report("high_count", got, want);
          if (got.normal_count != want.normal_count) report("normal_count", got, want);
          if (got.fail_count != want.fail_count) report("fail_count", got, want);
          if (got.drop_count != want.drop_count) report("drop_count", got, want);
        end
      end
      out_ch.ready <= no_idle || $urandom_range(0, 99) >= 36;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || (pending_cmds.size() == 0 &&
        expected_results.size() == 0))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_TIMEOUT: timeout_ms = value;
      CFG_GUARD:   guard_ms = value;
      CFG_ACK:     ack_id = value[7:0];
      default: ;
    endcase
    // drop valid low before the next write
    @(posedge clk);
  endtask

  // let the queue drain, then allow the copy and send pipeline to settle
  task automatic drain();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4 * ITEM_MAX) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) add_packet($urandom_range(1, 8), 1'($urandom_range(0, 1)));
      else if (r < 50) pending_cmds.push_back(mk(MODE_DISPATCH, 8'($urandom), 1'($urandom),
          1'($urandom), 3'($urandom), $urandom_range(0, 9) != 0,
          ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : LINK_OK));
      else if (r < 65) pending_cmds.push_back(mk(MODE_DONE, 8'($urandom), 1'($urandom),
          active_high_guess(), 3'($urandom_range(0, 7))));
      else if (r < 85) add_ticks($urandom_range(1, 6));
      else if (r < 90) pending_cmds.push_back(mk(MODE_CONN_RST, 8'($urandom), 1'($urandom)));
      else if (r < 93) pending_cmds.push_back(mk(3'($urandom_range(5, 7)), 8'($urandom),
          1'($urandom), 1'($urandom), 3'($urandom), 1'($urandom), 2'($urandom)));
      else if (r < 95) add_packet($urandom_range(60, 66), 0);
      else pending_cmds.push_back(mk(MODE_BYTE, 8'($urandom), 0));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.mode = MODE_TICK; in_ch.in_byte = 0; in_ch.in_last = 0;
    in_ch.done_queue = 0; in_ch.done_slot = 0; in_ch.device_configured = 0;
    in_ch.link_result = LINK_OK;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_TIMEOUT; cfg_ch.data = 0;
    timeout_ms = TIMEOUT_RST; guard_ms = GUARD_RST; ack_id = ACK_RST;
    stage_len = 0; hi_head = 0; hi_fill = 0; nm_head = 0; nm_fill = 0;
    in_flight = 0; active_high = 0;
    now_ms = 0; start_ms = 0; guard_until = 0; fail_total = 0; dropped_total = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values first, then each corner
    pending_cmds.push_back(mk(MODE_DISPATCH));
    add_ticks(4);
    pending_cmds.push_back(mk(MODE_DISPATCH, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(MODE_BYTE, 8'hff, 1));
    pending_cmds.push_back(mk(MODE_BYTE, 8'h00, 0));
    pending_cmds.push_back(mk(MODE_BYTE, 8'h00, 0));
    pending_cmds.push_back(mk(MODE_BYTE, 8'h00, 1));
    pending_cmds.push_back(mk(MODE_DISPATCH, 0, 0, 0, 0, 1, LINK_BUSY));
    pending_cmds.push_back(mk(MODE_DISPATCH, 0, 0, 0, 0, 1, 2'd2));
    pending_cmds.push_back(mk(MODE_DISPATCH, 0, 0, 0, 0, 1, 2'd3));
    pending_cmds.push_back(mk(MODE_DISPATCH));
    pending_cmds.push_back(mk(MODE_DONE, 0, 0, 0, 3'd7));
    pending_cmds.push_back(mk(MODE_DONE, 0, 0, 1, 0));
    pending_cmds.push_back(mk(MODE_DONE, 0, 0, 1, 3'd7));
    pending_cmds.push_back(mk(3'd7, 8'hff, 1, 1, 3'd7, 1, 2'd3));
    pending_cmds.push_back(mk(MODE_CONN_RST));
    drain();

    // full queues, overlong packet, timeout drop with the shortest settings
    write_reg(CFG_TIMEOUT, 16'd1);
    write_reg(CFG_GUARD, 16'd0);
    write_reg(CFG_ACK, 16'h00ff);
    write_reg(2'd3, 16'hffff);
    // restart the guard with zero length so that dispatch is free
    pending_cmds.push_back(mk(MODE_CONN_RST));
    for (int i = 0; i < 5; i++) add_packet(3, 1);
    for (int i = 0; i < 9; i++) add_packet(1, 0);
    add_packet(ITEM_MAX + 1, 0);
    pending_cmds.push_back(mk(MODE_DISPATCH));
    add_ticks(1);
    pending_cmds.push_back(mk(MODE_DISPATCH));
    pending_cmds.push_back(mk(MODE_DISPATCH));
    add_ticks(1);
    pending_cmds.push_back(mk(MODE_DISPATCH));
    pending_cmds.push_back(mk(MODE_CONN_RST));
    drain();

    no_idle = 1'b1;
    write_reg(CFG_TIMEOUT, 16'hffff);
    write_reg(CFG_GUARD, 16'hffff);
    write_reg(CFG_ACK, 16'h0000);
    random_phase(5);
    drain();
    no_idle = 1'b0;

    write_reg(CFG_TIMEOUT, 16'd5);
    write_reg(CFG_GUARD, 16'd3);
    write_reg(CFG_ACK, 16'($urandom_range(0, 255)));
    random_phase(5);
    drain();

    write_reg(CFG_TIMEOUT, 16'd12);
    write_reg(CFG_GUARD, 16'd0);
    random_phase(5);
    drain();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
